FILE: hdl/igap_pkg.sv
`default_nettype none

package igap_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int MAX_DIM      = 64;

  localparam int DIM_W   = 7;
  localparam int NC_W    = 9;
  localparam int CH_W    = 8;
  localparam int ZP_W    = 8;
  localparam int MULT_W  = 31;
  localparam int SHIFT_W = 6;
  localparam int SMP_W   = 8;
  localparam int SUM_W   = 20;
  localparam int PIX_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int AREA_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DIFF_W  = 22;
  localparam int PROD_W  = DIFF_W + MULT_W + 1;
  localparam int RND_W   = 64;
  localparam int SAT_W   = 10;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 31;

  localparam logic [IDX_W-1:0] REG_IN_HEIGHT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IN_WIDTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHANNELS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_IN_ZP       = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_ZP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCALE_MULT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCALE_SHIFT = 3'd6;

  localparam logic [DIM_W-1:0]   RST_IN_HEIGHT   = 7'd1;
  localparam logic [DIM_W-1:0]   RST_IN_WIDTH    = 7'd1;
  localparam logic [NC_W-1:0]    RST_CHANNELS    = 9'd1;
  localparam logic [ZP_W-1:0]    RST_IN_ZP       = 8'd0;
  localparam logic [ZP_W-1:0]    RST_OUT_ZP      = 8'd0;
  localparam logic [MULT_W-1:0]  RST_SCALE_MULT  = 31'd1073741824;
  localparam logic [SHIFT_W-1:0] RST_SCALE_SHIFT = 6'd31;

  // clamped, ready-to-use configuration
  typedef struct packed {
    logic [AREA_W-1:0]        area;
    logic [NC_W-1:0]          nc;
    logic signed [ZP_W-1:0]   in_zp;
    logic signed [ZP_W-1:0]   out_zp;
    logic [MULT_W-1:0]        mult;
    logic [SHIFT_W-1:0]       shift;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last_ch;
  } tag_t;

  // completed channel sum handed to the requantizer
  typedef struct packed {
    logic                    vld;
    tag_t                    tag;
    logic signed [SUM_W-1:0] sum;
  } acc_t;

endpackage

`default_nettype wire

FILE: hdl/igap_accum.sv
`default_nettype none

module igap_accum
  import igap_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SMP_W-1:0] in_sample,
  output acc_t                         acc,
  input  wire logic                    acc_ready
);

  logic [SUM_W-1:0] mem [MAX_CHANNELS];

  logic [CH_W-1:0]  ch_pos_r, ch_pos_nxt;
  logic [PIX_W-1:0] pix_pos_r, pix_pos_nxt;

  logic                    s1_v_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic signed [SMP_W-1:0] s1_x_r;
  logic                    s1_first_r;
  logic                    s1_lastpix_r;
  logic                    s1_lastch_r;
  logic                    fwd_r;
  logic [SUM_W-1:0]        fwd_data_r;
  logic [SUM_W-1:0]        rd_data_r;

  logic             accept, s1_go, s1_free;
  logic             first_pix, last_pix, last_ch;
  logic [AREA_W-1:0] pix_inc;
  logic [NC_W-1:0]  ch_inc;
  logic [SUM_W-1:0] operand, x_ext, s1_sum;

  assign pix_inc   = {1'b0, pix_pos_r} + AREA_W'(1);
  assign ch_inc    = {1'b0, ch_pos_r} + NC_W'(1);
  assign first_pix = (pix_pos_r == '0);
  assign last_pix  = (pix_inc >= cfg.area);
  assign last_ch   = (ch_inc >= cfg.nc);

  // s1 leaves when it holds no result or the requantizer takes it
  assign s1_go    = s1_v_r && (!s1_lastpix_r || acc_ready);
  assign s1_free  = !s1_v_r || s1_go;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  always_comb begin
    ch_pos_nxt  = ch_pos_r;
    pix_pos_nxt = pix_pos_r;
    if (accept) begin
      if (last_ch) begin
        ch_pos_nxt  = '0;
        pix_pos_nxt = last_pix ? '0 : pix_inc[PIX_W-1:0];
      end else begin
        ch_pos_nxt = ch_inc[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_pos_r  <= '0;
      pix_pos_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      ch_pos_r  <= ch_pos_nxt;
      pix_pos_r <= pix_pos_nxt;
      if (s1_free) s1_v_r <= in_valid;
    end
  end

  // read-modify-write; a write to the entry being read this cycle is forwarded
  assign operand = fwd_r ? fwd_data_r : rd_data_r;
  assign x_ext   = {{(SUM_W-SMP_W){s1_x_r[SMP_W-1]}}, s1_x_r};
  assign s1_sum  = s1_first_r ? x_ext : operand + x_ext;

  always_ff @(posedge clk) begin
    if (s1_go) mem[s1_ch_r] <= s1_sum;
    if (accept) begin
      rd_data_r    <= mem[ch_pos_r];
      fwd_r        <= s1_go && (s1_ch_r == ch_pos_r);
      fwd_data_r   <= s1_sum;
      s1_ch_r      <= ch_pos_r;
      s1_x_r       <= in_sample;
      s1_first_r   <= first_pix;
      s1_lastpix_r <= last_pix;
      s1_lastch_r  <= last_ch;
    end
  end

  assign acc.vld         = s1_v_r && s1_lastpix_r;
  assign acc.tag.ch      = s1_ch_r;
  assign acc.tag.last_ch = s1_lastch_r;
  assign acc.sum         = signed'(s1_sum);

endmodule

`default_nettype wire

FILE: hdl/igap_requant.sv
`default_nettype none

module igap_requant
  import igap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire acc_t              acc,
  output logic                   acc_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        out_channel_index,
  output logic signed [SMP_W-1:0] out_pooled_value,
  output logic                   out_last_channel
);

  logic signed [DIFF_W-1:0] zp_area_r;

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, o_v_r;
  tag_t a_tag_r, b_tag_r, c_tag_r, d_tag_r, e_tag_r, o_tag_r;
  logic signed [SUM_W-1:0]  a_sum_r;
  logic signed [DIFF_W-1:0] b_diff_r;
  logic signed [PROD_W-1:0] c_prod_r;
  logic signed [RND_W-1:0]  d_rnd_r;
  logic signed [SAT_W-1:0]  e_sat_r;
  logic signed [SMP_W-1:0]  o_val_r;

  logic o_rdy, e_rdy, d_rdy, c_rdy, b_rdy, a_rdy;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [RND_W-1:0]         half;
  logic signed [RND_W-1:0]  rnd, shifted;
  logic signed [SAT_W-1:0]  sat;
  logic signed [SAT_W:0]    biased;
  logic signed [SMP_W-1:0]  val;

  assign o_rdy = !o_v_r || !out_stall;
  assign e_rdy = !e_v_r || o_rdy;
  assign d_rdy = !d_v_r || e_rdy;
  assign c_rdy = !c_v_r || d_rdy;
  assign b_rdy = !b_v_r || c_rdy;
  assign a_rdy = !a_v_r || b_rdy;
  assign acc_ready = a_rdy;

  // the user must keep config static while items flow; the block does not enforce it
  always_ff @(posedge clk) begin
    zp_area_r <= DIFF_W'(signed'({1'b0, cfg.area}) * cfg.in_zp);
  end

  assign diff = {{(DIFF_W-SUM_W){a_sum_r[SUM_W-1]}}, a_sum_r} - zp_area_r;
  assign prod = PROD_W'(b_diff_r * signed'({1'b0, cfg.mult}));
  assign half = (cfg.shift == '0) ? '0 : (RND_W'(1) << (cfg.shift - SHIFT_W'(1)));
  assign rnd  = {{(RND_W-PROD_W){c_prod_r[PROD_W-1]}}, c_prod_r} + signed'(half);
  assign shifted = d_rnd_r >>> cfg.shift;

  // pre-clamp to a range that still saturates correctly after the zero point
  always_comb begin
    if (shifted > 64'sd511) sat = 10'sd511;
    else if (shifted < -64'sd512) sat = -10'sd512;
    else sat = shifted[SAT_W-1:0];
  end

  assign biased = {e_sat_r[SAT_W-1], e_sat_r}
                + {{(SAT_W+1-ZP_W){cfg.out_zp[ZP_W-1]}}, cfg.out_zp};

  always_comb begin
    if (biased > 11'sd127) val = 8'sd127;
    else if (biased < -11'sd128) val = -8'sd128;
    else val = biased[SMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= acc.vld;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
      if (d_rdy) d_v_r <= c_v_r;
      if (e_rdy) e_v_r <= d_v_r;
      if (o_rdy) o_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_sum_r <= acc.sum;
      a_tag_r <= acc.tag;
    end
    if (b_rdy) begin
      b_diff_r <= diff;
      b_tag_r  <= a_tag_r;
    end
    if (c_rdy) begin
      c_prod_r <= prod;
      c_tag_r  <= b_tag_r;
    end
    if (d_rdy) begin
      d_rnd_r <= rnd;
      d_tag_r <= c_tag_r;
    end
    if (e_rdy) begin
      e_sat_r <= sat;
      e_tag_r <= d_tag_r;
    end
    if (o_rdy) begin
      o_val_r <= val;
      o_tag_r <= e_tag_r;
    end
  end

  assign out_valid         = o_v_r;
  assign out_channel_index = o_tag_r.ch;
  assign out_pooled_value  = o_val_r;
  assign out_last_channel  = o_tag_r.last_ch;

endmodule

`default_nettype wire

FILE: hdl/int8_global_average_pool.sv
// int8 global average pool with integer requantization.
// Input channel (in_valid / in_stall / in_sample): one int8 tensor element per
// item, height-width-channel order. Items are taken one per cycle while in_stall
// is low; the channel-sum memory does one read-modify-write per item, read on
// acceptance and written from s1, and back-to-back same-channel hits are forwarded.
// Output channel (out_valid / out_stall / out_*): one result per item of the
// last spatial position, carrying the channel, its saturated average and a
// flag on the final channel. The requantizer is a 6-stage pipeline (input,
// offset, 22x32 multiply, rounding add, shift, zero point and saturation into
// the output register). When the receiver stalls, the result holds and the
// pipeline keeps filling its empty stages; input stalls only once the pipeline
// is full back to the sum memory.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; the user must write it while the block is idle, the block does not enforce it.
// Reset restores the register defaults and zeroes the position counters;
// the sum memory is not cleared, the first spatial position overwrites it.
`default_nettype none

module int8_global_average_pool
  import igap_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [SMP_W-1:0]  in_sample,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [CH_W-1:0]               out_channel_index,
  output logic signed [SMP_W-1:0]       out_pooled_value,
  output logic                          out_last_channel,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data
);

  logic [DIM_W-1:0]   height_r, width_r;
  logic [NC_W-1:0]    channels_r;
  logic [ZP_W-1:0]    in_zp_r, out_zp_r;
  logic [MULT_W-1:0]  mult_r;
  logic [SHIFT_W-1:0] shift_r;

  logic [DIM_W-1:0] h, w;
  logic [NC_W-1:0]  nc;
  cfg_t             cfg;
  acc_t             acc;
  logic             acc_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= RST_IN_HEIGHT;
      width_r    <= RST_IN_WIDTH;
      channels_r <= RST_CHANNELS;
      in_zp_r    <= RST_IN_ZP;
      out_zp_r   <= RST_OUT_ZP;
      mult_r     <= RST_SCALE_MULT;
      shift_r    <= RST_SCALE_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_HEIGHT:   height_r   <= cfg_data[DIM_W-1:0];
        REG_IN_WIDTH:    width_r    <= cfg_data[DIM_W-1:0];
        REG_CHANNELS:    channels_r <= cfg_data[NC_W-1:0];
        REG_IN_ZP:       in_zp_r    <= cfg_data[ZP_W-1:0];
        REG_OUT_ZP:      out_zp_r   <= cfg_data[ZP_W-1:0];
        REG_SCALE_MULT:  mult_r     <= cfg_data[MULT_W-1:0];
        REG_SCALE_SHIFT: shift_r    <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero is taken as one, oversize is clamped
  always_comb begin
    h  = (height_r == '0) ? DIM_W'(1)
       : (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;
    w  = (width_r == '0) ? DIM_W'(1)
       : (width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
    nc = (channels_r == '0) ? NC_W'(1)
       : (channels_r > NC_W'(MAX_CHANNELS)) ? NC_W'(MAX_CHANNELS) : channels_r;
  end

  assign cfg.area   = AREA_W'(h) * AREA_W'(w);
  assign cfg.nc     = nc;
  assign cfg.in_zp  = signed'(in_zp_r);
  assign cfg.out_zp = signed'(out_zp_r);
  assign cfg.mult   = mult_r;
  assign cfg.shift  = shift_r;

  igap_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .acc       (acc),
    .acc_ready (acc_ready)
  );

  igap_requant u_requant (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .acc               (acc),
    .acc_ready         (acc_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_pooled_value  (out_pooled_value),
    .out_last_channel  (out_last_channel)
  );

endmodule

`default_nettype wire

FILE: tb/tb_int8_global_average_pool.sv
`timescale 1ns / 100ps

module tb_int8_global_average_pool;
  import igap_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_ROWS       = 44;

  // index past the last register; writes to it must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [IDX_W-1:0]        idx;
    logic [CFG_W-1:0]        data;
    logic signed [SMP_W-1:0] smp;
    logic                    typed;
    logic signed [SMP_W-1:0] exp_val;
  } dir_row_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic signed [SMP_W-1:0] val;
    logic                    last;
  } avg_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CH_W-1:0]         out_channel_index;
  logic signed [SMP_W-1:0] out_pooled_value;
  logic                    out_last_channel;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  int8_global_average_pool dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_pooled_value  (out_pooled_value),
    .out_last_channel  (out_last_channel),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // pooling model state
  logic [DIM_W-1:0]        pool_h = RST_IN_HEIGHT;
  logic [DIM_W-1:0]        pool_w = RST_IN_WIDTH;
  logic [NC_W-1:0]         pool_nc = RST_CHANNELS;
  logic signed [ZP_W-1:0]  pool_izp = RST_IN_ZP;
  logic signed [ZP_W-1:0]  pool_ozp = RST_OUT_ZP;
  logic [MULT_W-1:0]       pool_mult = RST_SCALE_MULT;
  logic [SHIFT_W-1:0]      pool_shift = RST_SCALE_SHIFT;
  logic signed [SUM_W-1:0] pool_sums [MAX_CHANNELS];
  logic [CH_W-1:0]         pool_ch = '0;
  int unsigned             pool_pix = 0;

  avg_t        pending_avgs [$];
  avg_t        want_avg;
  int          fail_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  dir_row_t    directed_rows [N_ROWS];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [CFG_W-1:0] with_junk_bits(logic [CFG_W-1:0] v, int w);
    logic [CFG_W-1:0] m;
    m = (CFG_W'(1) << w) - CFG_W'(1);
    return (CFG_W'($urandom) & ~m) | (v & m);
  endfunction

  // accumulate one element; on the last spatial position queue the channel average
  task automatic accumulate_sample(input logic signed [SMP_W-1:0] s, input bit typed,
                                   input logic signed [SMP_W-1:0] typed_val);
    int unsigned             area, nc;
    logic signed [SUM_W-1:0] s_ext, sum;
    longint                  diff, prod, v;
    bit                      last_pix, last_ch;
    avg_t                    r;
    area = clamp_size(pool_h, MAX_DIM) * clamp_size(pool_w, MAX_DIM);
    nc = clamp_size(pool_nc, MAX_CHANNELS);
    last_pix = (pool_pix + 1 >= area);
    last_ch = (int'(pool_ch) + 1 >= nc);
    s_ext = {{(SUM_W-SMP_W){s[SMP_W-1]}}, s};
    sum = (pool_pix == 0) ? s_ext : pool_sums[pool_ch] + s_ext;
    pool_sums[pool_ch] = sum;
    if (last_pix) begin
      diff = longint'(sum) - longint'(pool_izp) * longint'(area);
      prod = diff * longint'(pool_mult);
      if (pool_shift != 0) prod += longint'(1) << (pool_shift - 1);
      v = (prod >>> pool_shift) + longint'(pool_ozp);
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      r.ch = pool_ch;
      r.val = typed ? typed_val : v[SMP_W-1:0];
      r.last = last_ch;
      pending_avgs.push_back(r);
    end
    if (last_ch) begin
      pool_ch = '0;
      pool_pix = last_pix ? 0 : pool_pix + 1;
    end else begin
      pool_ch = pool_ch + 1'b1;
    end
  endtask

  task automatic send_sample(input logic signed [SMP_W-1:0] s, input bit typed,
                             input logic signed [SMP_W-1:0] typed_val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_sample <= SMP_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    accumulate_sample(s, typed, typed_val);
    items_sent++;
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IN_HEIGHT:   pool_h = data[DIM_W-1:0];
      REG_IN_WIDTH:    pool_w = data[DIM_W-1:0];
      REG_CHANNELS:    pool_nc = data[NC_W-1:0];
      REG_IN_ZP:       pool_izp = data[ZP_W-1:0];
      REG_OUT_ZP:      pool_ozp = data[ZP_W-1:0];
      REG_SCALE_MULT:  pool_mult = data[MULT_W-1:0];
      REG_SCALE_SHIFT: pool_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one whole feature map with fresh settings; sends until both positions wrap
  task automatic random_map(input bit full_size);
    int unsigned             h, w, nc, eff_h, area, cut, pick;
    logic [MULT_W-1:0]       mult;
    logic [SHIFT_W-1:0]      shift;
    bit                      extreme_fill, mid_change;
    logic signed [SMP_W-1:0] fill;
    pick = $urandom_range(0, 23);
    if (full_size) begin
      // full height, narrow width
      h = MAX_DIM; w = MAX_DIM / 8; nc = 1;
    end else if (pick == 0) begin
      h = 1; w = 1; nc = $urandom_range(MAX_CHANNELS + 1, 511);
    end else if (pick == 1) begin
      h = $urandom_range(MAX_DIM, 127); w = 1; nc = 1;
    end else if (pick == 2) begin
      h = $urandom_range(0, 1); w = $urandom_range(MAX_DIM, 127); nc = $urandom_range(1, 2);
    end else if (pick == 3) begin
      h = 1; w = 1; nc = MAX_CHANNELS;
    end else begin
      h = $urandom_range(0, 4); w = $urandom_range(0, 4); nc = $urandom_range(0, 8);
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        mult = MULT_W'($urandom);
        shift = SHIFT_W'($urandom_range(28, 40));
      end
      2: begin
        mult = MULT_W'($urandom);
        shift = SHIFT_W'($urandom_range(0, 63));
      end
      default: begin
        mult = $urandom_range(0, 1) ? {MULT_W{1'b1}} : MULT_W'($urandom_range(0, 1));
        shift = $urandom_range(0, 1) ? {SHIFT_W{1'b1}} : '0;
      end
    endcase
    write_reg(REG_IN_HEIGHT, with_junk_bits(CFG_W'(h), DIM_W));
    write_reg(REG_IN_WIDTH, with_junk_bits(CFG_W'(w), DIM_W));
    write_reg(REG_CHANNELS, with_junk_bits(CFG_W'(nc), NC_W));
    write_reg(REG_IN_ZP, CFG_W'($urandom));
    write_reg(REG_OUT_ZP, CFG_W'($urandom));
    write_reg(REG_SCALE_MULT, with_junk_bits(CFG_W'(mult), MULT_W));
    write_reg(REG_SCALE_SHIFT, with_junk_bits(CFG_W'(shift), SHIFT_W));

    extreme_fill = full_size || ($urandom_range(0, 7) == 0);
    fill = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
    eff_h = clamp_size(h, MAX_DIM);
    area = eff_h * clamp_size(w, MAX_DIM);
    mid_change = !full_size && eff_h > 1 && ($urandom_range(0, 5) == 0);
    if (mid_change) begin
      // set the map height to at most its current value after some whole positions; sums stay written
      cut = $urandom_range(1, area - 1);
      while (pool_pix != cut)
        send_sample(extreme_fill ? fill : SMP_W'($urandom), 1'b0, '0);
      write_reg(REG_IN_HEIGHT, with_junk_bits(CFG_W'($urandom_range(1, eff_h)), DIM_W));
    end
    do send_sample(extreme_fill ? fill : SMP_W'($urandom), 1'b0, '0);
    while (pool_pix != 0 || pool_ch != 0);
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: result with nothing expected: ch %0d value %0d last %0b", $time,
                 out_channel_index, out_pooled_value, out_last_channel);
        fail_count++;
      end else begin
        want_avg = pending_avgs.pop_front();
        if (out_channel_index !== want_avg.ch) begin
          $display("%0t: channel_index expected %0d got %0d", $time, want_avg.ch,
                   out_channel_index);
          fail_count++;
        end
        if (out_pooled_value !== want_avg.val) begin
          $display("%0t: pooled_value expected %0d got %0d", $time, want_avg.val,
                   out_pooled_value);
          fail_count++;
        end
        if (out_last_channel !== want_avg.last) begin
          $display("%0t: last_channel expected %0b got %0b", $time, want_avg.last,
                   out_last_channel);
          fail_count++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_avgs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_CHANNELS; i++) pool_sums[i] = '0;
    // typed values hold for 1x1x1 maps: channel 0, last channel set
    directed_rows = '{
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd0, 1'b1, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, 8'sd64},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd128, 1'b1, -8'sd64},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd1, 1'b1, 8'sd1},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd1, 1'b1, 8'sd0},
      '{ROW_CFG, REG_SCALE_MULT, 31'h7FFF_FFFF, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_SCALE_SHIFT, 31'd0, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, 8'sd127},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd128, 1'b1, -8'sd128},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd0, 1'b1, 8'sd0},
      '{ROW_CFG, REG_SCALE_MULT, 31'd1, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_OUT_ZP, 31'h0000_007F, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, 8'sd127},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd128, 1'b1, -8'sd1},
      '{ROW_CFG, REG_OUT_ZP, 31'h7FFF_FF80, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd1, 1'b1, -8'sd128},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, -8'sd1},
      '{ROW_CFG, REG_IN_ZP, 31'h0000_007F, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, -8'sd128},
      '{ROW_CFG, REG_IN_ZP, 31'h7FFF_FF80, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_OUT_ZP, 31'd0, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b1, 8'sd127},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd128, 1'b1, 8'sd0},
      '{ROW_CFG, REG_SCALE_SHIFT, 31'd63, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_SCALE_MULT, 31'h7FFF_FFFF, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_IN_ZP, 31'd0, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd128, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd127, 1'b0, 8'sd0},
      '{ROW_CFG, REG_UNUSED, 31'h5A5A_5A5A, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_SCALE_SHIFT, 31'd31, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_SCALE_MULT, 31'h4000_0000, 8'sd0, 1'b0, 8'sd0},
      // zero sizes count as one
      '{ROW_CFG, REG_CHANNELS, 31'd0, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_IN_HEIGHT, 31'd0, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_IN_WIDTH, 31'd2, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd10, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd20, 1'b0, 8'sd0},
      // height cut to one after the first position: next position is the last
      '{ROW_CFG, REG_IN_HEIGHT, 31'd3, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_IN_WIDTH, 31'd1, 8'sd0, 1'b0, 8'sd0},
      '{ROW_CFG, REG_CHANNELS, 31'd2, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd55, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd77, 1'b0, 8'sd0},
      '{ROW_CFG, REG_IN_HEIGHT, 31'd1, 8'sd0, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, 8'sd100, 1'b0, 8'sd0},
      '{ROW_ITEM, REG_IN_HEIGHT, 31'd0, -8'sd3, 1'b0, 8'sd0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].exp_val);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      random_map(1'b0);
    end
    no_idle = 1'b0;
    random_map(1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
hdl/igap_pkg.sv
hdl/igap_accum.sv
hdl/igap_requant.sv
hdl/int8_global_average_pool.sv
tb/tb_int8_global_average_pool.sv
